>>> design/i2cmrt_pkg.sv
// Shared types and constants for the I2C register transaction sequencer.
package i2cmrt_pkg;

  // Write buffer size, fixed by the 4-bit buffer position field.
  localparam int BUF_DEPTH = 16;
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_START_W = 2'd1,
    MODE_START_R = 2'd2,
    MODE_EVENT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDRW = 3'd1,
    PH_REG   = 3'd2,
    PH_WDATA = 3'd3,
    PH_WSTOP = 3'd4,
    PH_ADDRR = 3'd5,
    PH_RDATA = 3'd6,
    PH_RSTOP = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_ADDRW_NACK = 3'd1,
    ERR_REG_NACK   = 3'd2,
    ERR_DATA_NACK  = 3'd3,
    ERR_ADDRR_NACK = 3'd4,
    ERR_NO_ACK_REQ = 3'd5,
    ERR_UNEXPECTED = 3'd6
  } err_t;

  // Input beat payload, last declared field in the low bits.
  typedef struct packed {
    logic [5:0] pad;
    logic       ack_requested;
    logic       slave_acked;
    logic [3:0] buf_index;
    logic [7:0] data_byte;
    logic [4:0] length;
    logic [7:0] reg_index;
    logic [6:0] slave_addr;
  } item_t;

  // Result beat payload, last declared field in the low bits.
  typedef struct packed {
    logic [1:0] pad;
    logic       busy_res;
    err_t       error_code;
    logic       done_res;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ack_out;
    logic       gen_stop;
    logic       gen_start;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

endpackage

>>> design/i2c_master_register_transaction.sv
// I2C master register read/write sequencer, top level.
//
// Input channel s_axis: tuser carries the mode (load write byte, start write,
// start read, bus event), tdata the address, register index, length, data
// byte, buffer position and the two bus event flags. Each input beat gives
// exactly one result beat on m_axis: the byte to send, start/stop requests,
// the master ACK level, a received byte with its position, done, an error
// code and the busy flag.
// A beat taken is held in the input register, processed through the phase
// logic into the result register once m_axis is ready, and shown on m_axis
// from there.
// Throughput: one beat per cycle when m_axis is ready, set by the single pass
// through the phase logic and the 16-entry write buffer read between the two
// registers. Reset returns the sequencer to idle and clears both valid flags;
// the write buffer keeps its contents and must be loaded before a write.
// When m_axis stalls the result register holds and the input register fills;
// s_axis_tready then drops until the result is taken.
module i2c_master_register_transaction (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // low to high: slave_addr, reg_index, length, data_byte, buf_index,
  // slave_acked, ack_requested, zero pad
  input  logic [i2cmrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // low to high: tx_valid, tx_byte, gen_start, gen_stop, ack_out, rx_valid,
  // rx_byte, rx_index, done_res, error_code, busy_res, zero pad
  output logic [i2cmrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import i2cmrt_pkg::*;

  // input register
  logic    in_valid;
  item_t   in_item;
  mode_t   in_mode;

  // result register
  logic    out_valid;
  result_t out_res;

  // sequencer state
  phase_t       phase, phase_next;
  logic [4:0]   byte_position, byte_position_next;
  logic [4:0]   byte_count, byte_count_next;
  logic [6:0]   target_addr, target_addr_next;
  logic [7:0]   target_reg, target_reg_next;
  logic         is_read, is_read_next;
  logic [7:0]   write_buffer [BUF_DEPTH];

  logic         out_ready;
  logic         exec;
  logic         buf_we;
  logic [4:0]   len_sat;
  logic [5:0]   rd_pos_inc;
  logic [7:0]   buf_rd;
  result_t      res;

  assign out_ready     = !out_valid || m_axis_tready;
  assign exec          = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res;

  assign len_sat    = (in_item.length > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : in_item.length;
  assign rd_pos_inc = {1'b0, byte_position} + 6'd1;
  assign buf_rd     = write_buffer[byte_position[BUF_IDX_W-1:0]];
  assign buf_we     = exec && (in_mode == MODE_LOAD) && (phase == PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= item_t'(s_axis_tdata);
      in_mode <= mode_t'(s_axis_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      write_buffer[in_item.buf_index[BUF_IDX_W-1:0]] <= in_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      byte_count    <= '0;
      target_addr   <= '0;
      target_reg    <= '0;
      is_read       <= 1'b0;
    end else if (exec) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      byte_count    <= byte_count_next;
      target_addr   <= target_addr_next;
      target_reg    <= target_reg_next;
      is_read       <= is_read_next;
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    byte_count_next    = byte_count;
    target_addr_next   = target_addr;
    target_reg_next    = target_reg;
    is_read_next       = is_read;
    case (in_mode)
      MODE_LOAD: begin
      end
      MODE_START_W, MODE_START_R: begin
        is_read_next       = (in_mode == MODE_START_R);
        // a zero-length read still fetches one byte
        byte_count_next    = ((in_mode == MODE_START_R) && (len_sat == 5'd0)) ? 5'd1
                                                                               : len_sat;
        byte_position_next = '0;
        target_addr_next   = in_item.slave_addr;
        target_reg_next    = in_item.reg_index;
        phase_next         = PH_ADDRW;
      end
      MODE_EVENT: begin
        case (phase)
          PH_ADDRW: begin
            if (!in_item.slave_acked) begin
              phase_next = PH_IDLE;
            end else begin
              byte_position_next = '0;
              phase_next         = PH_REG;
            end
          end
          PH_REG: begin
            if (!in_item.slave_acked) begin
              phase_next = PH_IDLE;
            end else if (is_read) begin
              phase_next = PH_ADDRR;
            end else if (byte_count == 5'd0) begin
              phase_next = PH_WSTOP;
            end else begin
              byte_position_next = 5'd1;
              phase_next         = PH_WDATA;
            end
          end
          PH_WDATA: begin
            if (!in_item.slave_acked || (byte_position >= byte_count)) begin
              phase_next = PH_IDLE;
            end else begin
              byte_position_next = byte_position + 5'd1;
            end
          end
          PH_ADDRR: begin
            if (!in_item.slave_acked) begin
              phase_next = PH_IDLE;
            end else begin
              byte_position_next = '0;
              phase_next         = PH_RDATA;
            end
          end
          PH_RDATA: begin
            if (!in_item.ack_requested) begin
              phase_next = PH_IDLE;
            end else begin
              byte_position_next = rd_pos_inc[4:0];
              if (rd_pos_inc >= {1'b0, byte_count}) begin
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    res = '0;
    case (in_mode)
      MODE_LOAD: begin
      end
      MODE_START_W, MODE_START_R: begin
        res.tx_valid  = 1'b1;
        res.tx_byte   = {in_item.slave_addr, 1'b0};
        res.gen_start = 1'b1;
      end
      MODE_EVENT: begin
        case (phase)
          PH_ADDRW: begin
            if (!in_item.slave_acked) begin
              res.error_code = ERR_ADDRW_NACK;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = target_reg;
            end
          end
          PH_REG: begin
            if (!in_item.slave_acked) begin
              res.error_code = ERR_REG_NACK;
            end else if (is_read) begin
              res.tx_valid  = 1'b1;
              res.tx_byte   = {target_addr, 1'b1};
              res.gen_start = 1'b1;
            end else if (byte_count == 5'd0) begin
              res.gen_stop = 1'b1;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = write_buffer[0];
            end
          end
          PH_WDATA: begin
            if (!in_item.slave_acked) begin
              res.error_code = ERR_DATA_NACK;
            end else if (byte_position >= byte_count) begin
              res.gen_stop = 1'b1;
              res.done_res = 1'b1;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = buf_rd;
            end
          end
          PH_WSTOP, PH_RSTOP: begin
            res.done_res = 1'b1;
          end
          PH_ADDRR: begin
            if (!in_item.slave_acked) begin
              res.error_code = ERR_ADDRR_NACK;
            end else begin
              res.ack_out = in_item.ack_requested;
            end
          end
          PH_RDATA: begin
            if (!in_item.ack_requested) begin
              res.error_code = ERR_NO_ACK_REQ;
            end else begin
              res.rx_valid = 1'b1;
              res.rx_byte  = in_item.data_byte;
              res.rx_index = byte_position[3:0];
              if (rd_pos_inc >= {1'b0, byte_count}) begin
                // last byte: NACK and stop
                res.gen_stop = 1'b1;
                res.done_res = 1'b1;
              end else begin
                res.ack_out = 1'b1;
              end
            end
          end
          default: begin
            res.error_code = ERR_UNEXPECTED;
          end
        endcase
        if (res.error_code != ERR_NONE) begin
          res.gen_stop = 1'b1;
          res.done_res = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.busy_res = (phase_next != PH_IDLE);
  end

`ifndef SYNTHESIS
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    exec && (res.error_code != ERR_NONE) |-> res.done_res && res.gen_stop && !res.busy_res)
    else $error("error result without done and stop");

  a_tx_rx_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.tx_valid && out_res.rx_valid))
    else $error("tx and rx valid in the same result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> !out_res.busy_res)
    else $error("done result still busy");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    exec && ((in_mode == MODE_START_W) || (in_mode == MODE_START_R)) |=> phase == PH_ADDRW)
    else $error("start did not enter address phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 5'(BUF_DEPTH))
    else $error("byte count beyond buffer depth");
`endif

endmodule
